@@ hw/rtl/move_to_position_p_control_top_assert.svh @@
// Assertion macros used by the checker file of the position controller.
`ifndef MOVE_TO_POSITION_P_CONTROL_TOP_ASSERT_SVH
`define MOVE_TO_POSITION_P_CONTROL_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("move_to_position_p_control_top: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("move_to_position_p_control_top: assertion failed");

`endif

@@ hw/rtl/mtp_pkg.sv @@
// Shared types and constants of the proportional position controller.
package mtp_pkg;

  localparam int unsigned GainW   = 16;
  localparam int unsigned SpeedW  = 8;
  localparam int unsigned TolW    = 16;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned PosW    = 16;
  localparam int unsigned GoalW   = PosW + 1;
  localparam int unsigned ErrW    = PosW + 2;
  localparam int unsigned MagW    = PosW + 1;
  localparam int unsigned ProdW   = GainW + MagW;
  localparam int unsigned QShift  = 8;
  localparam int unsigned DirW    = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;

  // Register indexes of the configuration channel.
  localparam logic [CfgIdxW-1:0] CfgGain     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxSpeed = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTol      = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSettle   = 2'd3;

  // Register reset values.
  localparam logic [GainW-1:0]  GainRst     = 16'd256;
  localparam logic [SpeedW-1:0] MaxSpeedRst = 8'd75;
  localparam logic [TolW-1:0]   TolRst      = 16'd5;
  localparam logic [TimeW-1:0]  SettleRst   = 16'd1000;

  // Drive direction codes.
  localparam logic [DirW-1:0] DirStop = 2'd0;
  localparam logic [DirW-1:0] DirFwd  = 2'd1;
  localparam logic [DirW-1:0] DirBwd  = 2'd2;

  typedef struct packed {
    logic [GainW-1:0]  gain;
    logic [SpeedW-1:0] max_speed;
    logic [TolW-1:0]   tolerance;
    logic [TimeW-1:0]  settle_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [PosW-1:0] move_counts;
    logic signed [PosW-1:0] position;
    logic [TimeW-1:0]       now_ms;
  } item_t;

  typedef struct packed {
    logic [SpeedW-1:0] drive_level;
    logic [DirW-1:0]   drive_dir;
    logic              done_res;
  } result_t;

endpackage

@@ hw/rtl/mtp_cfg_regs.sv @@
// Configuration register file of the position controller.
module mtp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [mtp_pkg::CfgIdxW-1:0]    wr_idx_i,
  input  logic [mtp_pkg::CfgDataW-1:0]   wr_data_i,
  output mtp_pkg::cfg_t                  cfg_o
);

  mtp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        mtp_pkg::CfgGain:     cfg_d.gain      = wr_data_i[mtp_pkg::GainW-1:0];
        mtp_pkg::CfgMaxSpeed: cfg_d.max_speed = wr_data_i[mtp_pkg::SpeedW-1:0];
        mtp_pkg::CfgTol:      cfg_d.tolerance = wr_data_i[mtp_pkg::TolW-1:0];
        mtp_pkg::CfgSettle:   cfg_d.settle_ms = wr_data_i[mtp_pkg::TimeW-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain      <= mtp_pkg::GainRst;
      cfg_q.max_speed <= mtp_pkg::MaxSpeedRst;
      cfg_q.tolerance <= mtp_pkg::TolRst;
      cfg_q.settle_ms <= mtp_pkg::SettleRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/mtp_ctrl_law.sv @@
// Move state and one-step proportional control law.
module mtp_ctrl_law (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  mtp_pkg::item_t   item_i,
  input  mtp_pkg::cfg_t    cfg_i,
  output mtp_pkg::result_t res_o
);

  logic signed [mtp_pkg::GoalW-1:0] goal_q, goal_d;
  logic                             busy_q, busy_d;
  logic                             settling_q, settling_d;
  logic [mtp_pkg::TimeW-1:0]        start_q, start_d;

  logic signed [mtp_pkg::GoalW-1:0] new_goal;
  logic signed [mtp_pkg::ErrW-1:0]  err;
  logic signed [mtp_pkg::ErrW-1:0]  err_neg;
  logic [mtp_pkg::MagW-1:0]         mag;
  logic [mtp_pkg::ProdW-1:0]        prod;
  logic [mtp_pkg::ProdW-mtp_pkg::QShift-1:0] scaled;
  logic [mtp_pkg::SpeedW-1:0]       level;
  logic [mtp_pkg::TimeW-1:0]        elapsed;
  logic                             settling_eff;
  logic                             in_tol;
  logic                             timed_out;

  // An idle block starts the move on this very step: the error is the distance.
  assign new_goal = mtp_pkg::GoalW'(item_i.position) + mtp_pkg::GoalW'(item_i.move_counts);
  assign err      = busy_q ? (mtp_pkg::ErrW'(goal_q) - mtp_pkg::ErrW'(item_i.position))
                           : mtp_pkg::ErrW'(item_i.move_counts);
  assign err_neg  = -err;
  assign mag      = err[mtp_pkg::ErrW-1] ? err_neg[mtp_pkg::MagW-1:0]
                                         : err[mtp_pkg::MagW-1:0];
  assign settling_eff = busy_q & settling_q;

  assign prod   = mtp_pkg::ProdW'(cfg_i.gain) * mtp_pkg::ProdW'(mag);
  assign scaled = prod[mtp_pkg::ProdW-1:mtp_pkg::QShift];
  assign level  = (scaled > (mtp_pkg::ProdW-mtp_pkg::QShift)'(cfg_i.max_speed))
                ? cfg_i.max_speed : scaled[mtp_pkg::SpeedW-1:0];

  assign in_tol    = mag < mtp_pkg::MagW'(cfg_i.tolerance);
  assign elapsed   = item_i.now_ms - start_q;
  assign timed_out = elapsed >= cfg_i.settle_ms;

  always_comb begin
    res_o      = '0;
    goal_d     = busy_q ? goal_q : new_goal;
    busy_d     = 1'b1;
    settling_d = settling_eff;
    start_d    = start_q;
    if (!settling_eff) begin
      res_o.drive_level = level;
      if (level != '0) begin
        res_o.drive_dir = err[mtp_pkg::ErrW-1] ? mtp_pkg::DirBwd : mtp_pkg::DirFwd;
      end
      if (in_tol) begin
        start_d    = item_i.now_ms;
        settling_d = 1'b1;
      end
    end else if (timed_out) begin
      busy_d         = 1'b0;
      res_o.done_res = 1'b1;
    end else if (!in_tol) begin
      settling_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q     <= '0;
      busy_q     <= 1'b0;
      settling_q <= 1'b1;
      start_q    <= '0;
    end else if (step_i) begin
      goal_q     <= goal_d;
      busy_q     <= busy_d;
      settling_q <= settling_d;
      start_q    <= start_d;
    end
  end

endmodule

@@ hw/rtl/move_to_position_p_control_top.sv @@
// Top level of the proportional move-to-position controller.
// Usage:
// - Slave stream: one control tick per transfer; s_axis_tdata carries the move
//   distance, the encoder count and the millisecond time. The distance is used
//   only when no move is active; that tick latches the goal and starts driving.
// - Master stream: exactly one result per tick, in order: drive level, drive
//   direction (stop, forward, backward) and a done flag on the tick that ends
//   a settled move.
// - Config channel: cfg_index_i selects gain (Q8.8), max speed, tolerance or
//   settle time; cfg_ready_o is always high. Write only while no tick is in
//   flight.
// - Pipeline: a tick is taken into the input register and its result into the
//   result register, which drives m_axis_tvalid. Throughput: one tick per cycle
//   while m_axis_tready is high, set by the single pass through the multiplier
//   and the compares between the input register and the result register.
// - Stall: the result register holds while m_axis_tready is low; the input
//   register keeps one more tick, then s_axis_tready drops.
// - Reset: both stages empty, registers at their defaults, no move active.
module move_to_position_p_control_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // {now_ms[47:32], position[31:16], move_counts[15:0]}
  input  logic [mtp_pkg::InDataW-1:0]     s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // {zero pad[15:11], done_res[10], drive_dir[9:8], drive_level[7:0]}
  output logic [mtp_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mtp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mtp_pkg::CfgDataW-1:0]    cfg_data_i
);

  mtp_pkg::cfg_t    cfg;
  mtp_pkg::item_t   item_q;
  mtp_pkg::result_t res;
  mtp_pkg::result_t res_q;
  logic             item_vld_q;
  logic             out_vld_q;
  logic             advance;
  logic             s_xfer;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  mtp_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // Advance the held tick when the result register is empty or being drained.
  assign advance       = item_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~item_vld_q | advance;
  assign s_xfer        = s_axis_tvalid & s_axis_tready;

  mtp_ctrl_law u_ctrl_law (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (s_xfer) begin
        item_vld_q <= 1'b1;
      end else if (advance) begin
        item_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload: capture on transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      item_q.move_counts <= s_axis_tdata[15:0];
      item_q.position    <= s_axis_tdata[31:16];
      item_q.now_ms      <= s_axis_tdata[47:32];
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, res_q.done_res, res_q.drive_dir, res_q.drive_level};

endmodule

@@ hw/rtl/mtp_checker.sv @@
// Port-level checker of the position controller and its bind.
`include "move_to_position_p_control_top_assert.svh"

module mtp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic [mtp_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready
);

  // A stopped motor has zero level, and a zero level is always a stop.
  `MTP_ASSERT_NOW(a_stop_iff_zero, clk_i, rst_ni, m_axis_tvalid,
    (m_axis_tdata[7:0] == 8'd0) == (m_axis_tdata[9:8] == mtp_pkg::DirStop))

  // Done is only reported during the motor-stopped wait.
  `MTP_ASSERT_NOW(a_done_stopped, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[10],
    m_axis_tdata[9:0] == 10'd0)

  // Padding bits above the fields stay zero.
  `MTP_ASSERT_NOW(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[15:11] == 5'd0)

  // A stalled result holds.
  `MTP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))

  // With the result register empty the input side always takes a transfer.
  `MTP_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

endmodule

bind move_to_position_p_control_top mtp_checker u_mtp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

@@ tb/tb_move_to_position_p_control_top.sv @@
// Self-checking testbench of the proportional move-to-position controller.
module tb_move_to_position_p_control_top;
  import mtp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PrintCap   = 50;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  move_to_position_p_control_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Controller mirror: registers and move state as the block should hold them.
  cfg_t                    cfg_regs;
  logic signed [GoalW-1:0] goal_q;
  logic                    busy_q;
  logic                    settling_q;
  logic [TimeW-1:0]        settle_start_q;

  result_t     drive_expect_q[$];
  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Stimulus trajectory: where the motor is and what the ms timer reads.
  int               sim_pos;
  logic [TimeW-1:0] ms_now;

  function automatic result_t predict_control_tick(input item_t it);
    result_t                r;
    logic signed [ErrW-1:0] err;
    logic [MagW-1:0]        mag;
    logic [ProdW-1:0]       prod;
    logic [TimeW-1:0]       elapsed;
    r = '0;
    // An idle tick latches a new goal and always starts driving.
    if (!busy_q) begin
      goal_q     = {it.position[PosW-1], it.position}
                 + {it.move_counts[PosW-1], it.move_counts};
      settling_q = 1'b0;
      busy_q     = 1'b1;
    end
    err = {goal_q[GoalW-1], goal_q} - {{2{it.position[PosW-1]}}, it.position};
    mag = err[ErrW-1] ? MagW'(-err) : MagW'(err);
    if (!settling_q) begin
      prod = (ProdW'(cfg_regs.gain) * ProdW'(mag)) >> QShift;
      r.drive_level = (prod > ProdW'(cfg_regs.max_speed)) ? cfg_regs.max_speed
                                                           : prod[SpeedW-1:0];
      if (r.drive_level != '0) begin
        r.drive_dir = err[ErrW-1] ? DirBwd : DirFwd;
      end else begin
        r.drive_dir = DirStop;
      end
      // Drive still goes out on this tick; waiting begins on the next one.
      if (mag < MagW'(cfg_regs.tolerance)) begin
        settle_start_q = it.now_ms;
        settling_q     = 1'b1;
      end
    end else begin
      elapsed = it.now_ms - settle_start_q;
      if (elapsed >= cfg_regs.settle_ms) begin
        busy_q    = 1'b0;
        r.done_res = 1'b1;
      end else if (mag >= MagW'(cfg_regs.tolerance)) begin
        settling_q = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= PrintCap) begin
      $display("mismatch on result %0d: %s got %0d expected %0d",
               result_count, what, got, want);
    end
  endtask

  // Compare every result transfer against the oldest pending expectation.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (drive_expect_q.size() == 0) begin
        report_mismatch("result with no tick pending", m_axis_tdata, 0);
      end else begin
        want = drive_expect_q.pop_front();
        if (m_axis_tdata[SpeedW-1:0] != want.drive_level) begin
          report_mismatch("drive_level", m_axis_tdata[SpeedW-1:0], want.drive_level);
        end
        if (m_axis_tdata[SpeedW +: DirW] != want.drive_dir) begin
          report_mismatch("drive_dir", m_axis_tdata[SpeedW +: DirW], want.drive_dir);
        end
        if (m_axis_tdata[SpeedW+DirW] != want.done_res) begin
          report_mismatch("done_res", m_axis_tdata[SpeedW+DirW], want.done_res);
        end
        if (m_axis_tdata[OutDataW-1:SpeedW+DirW+1] != '0) begin
          report_mismatch("pad bits", m_axis_tdata[OutDataW-1:SpeedW+DirW+1], 0);
        end
      end
      result_count++;
    end
  end

  // Receiver side: stall at the rate of the current phase.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int clamp_count(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Hold valid through the transfer; predict once the tick is taken.
  task automatic send_tick(input item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.now_ms, it.position, it.move_counts};
    do @(posedge clk_i); while (!s_axis_tready);
    drive_expect_q.push_back(predict_control_tick(it));
  endtask

  // Drop valid and wait until every pending result has come, plus the latency.
  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (drive_expect_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgGain:     cfg_regs.gain      = val;
      CfgMaxSpeed: cfg_regs.max_speed = val[SpeedW-1:0];
      CfgTol:      cfg_regs.tolerance = val;
      CfgSettle:   cfg_regs.settle_ms = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Build one tick that follows a plausible move: start, approach, settle.
  task automatic make_tick(output item_t it);
    int roll, span, lo, hi, delta, goal_i, tol_i, off, sgn;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) begin
      ms_now = $urandom_range(0, 65535);
    end else begin
      ms_now = ms_now + $urandom_range(0, cfg_regs.settle_ms / 4 + 40);
    end
    it.now_ms      = ms_now;
    it.move_counts = $urandom_range(0, 65535);
    if (!busy_q) begin
      // Pick the distance so that the goal stays reachable.
      span = (roll < 75) ? 3000 : 32768;
      if (roll >= 75) sim_pos = int'($urandom_range(0, 65535)) - 32768;
      lo = (-span > -32768 - sim_pos) ? -span : -32768 - sim_pos;
      hi = (span - 1 < 32767 - sim_pos) ? span - 1 : 32767 - sim_pos;
      delta = lo + int'($urandom_range(0, hi - lo));
      it.move_counts = delta[PosW-1:0];
    end else begin
      goal_i = int'(goal_q);
      tol_i  = int'(cfg_regs.tolerance);
      sgn    = $urandom_range(0, 1) ? 1 : -1;
      off    = (tol_i > 1) ? int'($urandom_range(0, (tol_i > 200) ? 200 : tol_i - 1)) : 0;
      if (roll < 10) begin
        sim_pos = int'($urandom_range(0, 65535)) - 32768;
      end else if (settling_q) begin
        // Mostly hold inside the band; now and then get knocked out of it.
        if (roll < 25) sim_pos = goal_i + sgn * (tol_i + int'($urandom_range(0, 40)));
        else sim_pos = goal_i + sgn * off;
      end else begin
        if (roll < 45) sim_pos = goal_i + sgn * off;
        else sim_pos = sim_pos + (goal_i - sim_pos) / 2 + int'($urandom_range(0, 6)) - 3;
      end
      sim_pos = clamp_count(sim_pos);
    end
    it.position = sim_pos[PosW-1:0];
  endtask

  task automatic test_reset_defaults();
    send_tick('{16'sd0, 16'sd0, 16'd0});
    send_tick('{$urandom_range(0, 65535), 16'sd100, 16'd10});
    send_tick('{$urandom_range(0, 65535), 16'sd90, 16'd20});
    send_tick('{$urandom_range(0, 65535), 16'sd3, 16'd30});
    send_tick('{$urandom_range(0, 65535), 16'sd0, 16'd1029});
    send_tick('{$urandom_range(0, 65535), 16'sd0, 16'd1030});
    // Extreme counts: goal far beyond the encoder range, full-width error.
    send_tick('{-16'sd32768, -16'sd32768, 16'd65530});
    send_tick('{16'sd32767, 16'sd32767, 16'd5});
  endtask

  task automatic test_register_extremes();
    wait_results_drained();
    write_reg(CfgGain, 16'hFFFF);
    write_reg(CfgMaxSpeed, 16'd255);
    write_reg(CfgTol, 16'hFFFF);
    write_reg(CfgSettle, 16'd0);
    send_tick('{$urandom_range(0, 65535), -16'sd32768, 16'd100});
    send_tick('{$urandom_range(0, 65535), 16'sd0, 16'd100});
    send_tick('{16'sd1, 16'sd0, 16'd200});
    send_tick('{$urandom_range(0, 65535), 16'sd0, 16'd200});
    // No gain and no tolerance band: stopped drive, never settles.
    wait_results_drained();
    write_reg(CfgGain, 16'd0);
    write_reg(CfgTol, 16'd0);
    write_reg(CfgSettle, 16'hFFFF);
    send_tick('{16'sd500, 16'sd0, 16'd300});
    send_tick('{$urandom_range(0, 65535), -16'sd32768, 16'd301});
    // Zero speed limit, then the longest settle time reached across the wrap.
    wait_results_drained();
    write_reg(CfgGain, 16'd1);
    write_reg(CfgMaxSpeed, 16'd0);
    write_reg(CfgTol, 16'd10);
    send_tick('{$urandom_range(0, 65535), 16'sd495, 16'd302});
    send_tick('{$urandom_range(0, 65535), 16'sd500, 16'd301});
    wait_results_drained();
    write_reg(CfgGain, GainRst);
    write_reg(CfgMaxSpeed, 16'd255);
    write_reg(CfgTol, TolRst);
    send_tick('{-16'sd7, 16'sd0, 16'd400});
    send_tick('{$urandom_range(0, 65535), -16'sd4, 16'd401});
    send_tick('{$urandom_range(0, 65535), 16'sd100, 16'd402});
    send_tick('{$urandom_range(0, 65535), -16'sd7, 16'd403});
    wait_results_drained();
    write_reg(CfgSettle, 16'd0);
    send_tick('{$urandom_range(0, 65535), -16'sd7, 16'd403});
  endtask

  task automatic test_random_moves(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned n_ticks);
    item_t it;
    wait_results_drained();
    write_reg(CfgGain, $urandom_range(0, 1) ? $urandom_range(64, 1024) : $urandom_range(0, 65535));
    write_reg(CfgMaxSpeed, $urandom_range(0, 255));
    write_reg(CfgTol, $urandom_range(1, 300));
    write_reg(CfgSettle, $urandom_range(0, 3000));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_ticks; i++) begin
      make_tick(it);
      send_tick(it);
      // Hold off now and then until the pipeline is empty.
      if (i % 100 == 99) wait_results_drained();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CfgGain;
    cfg_data_i     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    result_count   = 0;
    cycle_count    = 0;
    sim_pos        = 0;
    ms_now         = '0;
    cfg_regs       = '{GainRst, MaxSpeedRst, TolRst, SettleRst};
    goal_q         = '0;
    busy_q         = 1'b0;
    settling_q     = 1'b1;
    settle_start_q = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_random_moves(0, 0, 480);
    test_random_moves(70, 0, 480);
    test_random_moves(0, 70, 480);
    test_random_moves(32, 32, 480);

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && drive_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
